/* hdl/tpda_pkg.sv */
// Shared types, constants and helper functions for the two-way dispatch arbiter.
// Used by tpda_ctrl, tpda_dp and the top level; depends on nothing.
package tpda_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int LOAD_BITS   = 16;
  localparam int ID_W        = 7;
  localparam int ENTRY_W     = ID_W + 1 + LOAD_BITS;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_GRANTED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // last granted direction
  localparam logic [1:0] LAST_NONE = 2'd0;
  localparam logic [1:0] LAST_WEST = 2'd1;
  localparam logic [1:0] LAST_EAST = 2'd2;

  localparam logic [1:0] RUN_LIMIT = 2'd2;
  localparam logic [1:0] RUN_MAX   = 2'd3;

  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_DISP = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_ENQ, S_SCAN, S_SCMP, S_SHIFT, S_SHWR, S_DRD, S_DSEL
  } ctrl_state_t;

  typedef struct packed {
    logic       ld_item;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_fill;
    logic       pos_set;
    logic       rd_prev;
    logic       wr_shift;
    logic       wr_item;
    logic       res_ld;
    logic [1:0] res_code;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic idx_at_fill;
    logic idx_at_pos;
    logic beats;
    logic both_empty;
    logic out_free;
  } dp_sts_t;

  function automatic logic [ID_W-1:0] ent_id(input logic [ENTRY_W-1:0] e);
    return e[ENTRY_W-1 -: ID_W];
  endfunction

  function automatic logic ent_prio(input logic [ENTRY_W-1:0] e);
    return e[LOAD_BITS];
  endfunction

  function automatic logic [LOAD_BITS-1:0] ent_load(input logic [ENTRY_W-1:0] e);
    return e[LOAD_BITS-1:0];
  endfunction

  // logical queue position to ring address
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] b,
                                            input logic [CNT_W-1:0] l);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(b) + (CNT_W+1)'(l);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hdl/tpda_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module tpda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/tpda_ctrl.sv */
// Sequencing FSM for enqueue scan/shift and dispatch.
// Depends on tpda_pkg; drives tpda_dp through dp_cmd_t.
module tpda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  tpda_pkg::dp_sts_t sts,
  output tpda_pkg::dp_cmd_t cmd
);

  tpda_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == tpda_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpda_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == tpda_pkg::CMD_DISP) ? tpda_pkg::S_DRD : tpda_pkg::S_ENQ;
        end
      end
      tpda_pkg::S_ENQ: begin
        if (!sts.full) begin
          state_nxt = tpda_pkg::S_SCAN;
        end else if (sts.out_free) begin
          state_nxt = tpda_pkg::S_IDLE;
        end
      end
      tpda_pkg::S_SCAN:  state_nxt = sts.idx_at_fill ? tpda_pkg::S_SHIFT : tpda_pkg::S_SCMP;
      tpda_pkg::S_SCMP:  state_nxt = sts.beats ? tpda_pkg::S_SHIFT : tpda_pkg::S_SCAN;
      tpda_pkg::S_SHIFT: begin
        if (!sts.idx_at_pos) begin
          state_nxt = tpda_pkg::S_SHWR;
        end else if (sts.out_free) begin
          state_nxt = tpda_pkg::S_IDLE;
        end
      end
      tpda_pkg::S_SHWR:  state_nxt = tpda_pkg::S_SHIFT;
      tpda_pkg::S_DRD: begin
        if (!sts.both_empty) begin
          state_nxt = tpda_pkg::S_DSEL;
        end else if (sts.out_free) begin
          state_nxt = tpda_pkg::S_IDLE;
        end
      end
      tpda_pkg::S_DSEL: begin
        if (sts.out_free) begin
          state_nxt = tpda_pkg::S_IDLE;
        end
      end
      default: state_nxt = tpda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      tpda_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          cmd.idx_clr = 1'b1;
        end
      end
      tpda_pkg::S_ENQ: begin
        if (sts.full && sts.out_free) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = tpda_pkg::ST_FULL;
        end
      end
      tpda_pkg::S_SCAN: begin
        if (sts.idx_at_fill) begin
          cmd.pos_set = 1'b1;
        end
      end
      tpda_pkg::S_SCMP: begin
        if (sts.beats) begin
          cmd.pos_set  = 1'b1;
          cmd.idx_fill = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      tpda_pkg::S_SHIFT: begin
        if (!sts.idx_at_pos) begin
          cmd.rd_prev = 1'b1;
        end else if (sts.out_free) begin
          cmd.wr_item  = 1'b1;
          cmd.res_ld   = 1'b1;
          cmd.res_code = tpda_pkg::ST_ENQUEUED;
        end
      end
      tpda_pkg::S_SHWR: begin
        // data read from idx-1 last cycle moves up one slot
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
      end
      tpda_pkg::S_DRD: begin
        if (sts.both_empty && sts.out_free) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = tpda_pkg::ST_EMPTY;
        end
      end
      tpda_pkg::S_DSEL: begin
        if (sts.out_free) begin
          cmd.res_ld   = 1'b1;
          cmd.res_code = tpda_pkg::ST_GRANTED;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* hdl/tpda_dp.sv */
// Datapath: two ring-buffer queues in RAM, fill/base counters, grant history,
// scan index and the result register. Depends on tpda_pkg and tpda_ram.
module tpda_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tpda_pkg::dp_cmd_t              cmd,
  output tpda_pkg::dp_sts_t              sts,
  input  logic [tpda_pkg::ID_W-1:0]      in_train_id,
  input  logic                           in_heading,
  input  logic                           in_high_priority,
  input  logic [15:0]                    in_load_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [tpda_pkg::ID_W-1:0]      out_granted_id,
  output logic                           out_granted_heading
);

  localparam int EW = tpda_pkg::ENTRY_W;
  localparam int IW = tpda_pkg::IDX_W;
  localparam int CW = tpda_pkg::CNT_W;

  logic [EW-1:0] item_r;
  logic          dir_r;
  logic [CW-1:0] idx_r, pos_r;
  logic [CW-1:0] fill_w_r, fill_e_r;
  logic [IW-1:0] base_w_r, base_e_r;
  logic [1:0]    last_r, run_r;

  logic          out_valid_r, out_head_r;
  logic [1:0]    out_status_r;
  logic [tpda_pkg::ID_W-1:0] out_id_r;

  logic [EW-1:0] rdata_w, rdata_e, rdata_sel, wdata;
  logic [IW-1:0] raddr_w, raddr_e, waddr;
  logic [CW-1:0] lidx, fill_sel;
  logic          we_w, we_e, wr_any, out_free;
  logic          grant_dir, do_grant;
  logic [1:0]    last_nxt, run_nxt;
  logic [EW-1:0] head;

  assign lidx      = cmd.rd_prev ? (idx_r - CW'(1)) : idx_r;
  assign raddr_w   = tpda_pkg::phys(base_w_r, lidx);
  assign raddr_e   = tpda_pkg::phys(base_e_r, lidx);
  assign waddr     = tpda_pkg::phys(dir_r ? base_e_r : base_w_r, idx_r);
  assign rdata_sel = dir_r ? rdata_e : rdata_w;
  assign wdata     = cmd.wr_item ? item_r : rdata_sel;
  assign wr_any    = cmd.wr_item | cmd.wr_shift;
  assign we_w      = wr_any & ~dir_r;
  assign we_e      = wr_any & dir_r;
  assign fill_sel  = dir_r ? fill_e_r : fill_w_r;

  tpda_ram #(.WIDTH(EW), .DEPTH(tpda_pkg::QUEUE_DEPTH)) u_ram_w (
    .clk(clk), .we(we_w), .waddr(waddr), .wdata(wdata), .raddr(raddr_w), .rdata(rdata_w)
  );

  tpda_ram #(.WIDTH(EW), .DEPTH(tpda_pkg::QUEUE_DEPTH)) u_ram_e (
    .clk(clk), .we(we_e), .waddr(waddr), .wdata(wdata), .raddr(raddr_e), .rdata(rdata_e)
  );

  // new request beats a queued one: higher priority, or full key tie and lower id
  assign sts.beats = (tpda_pkg::ent_prio(item_r) & ~tpda_pkg::ent_prio(rdata_sel)) |
                     ((tpda_pkg::ent_prio(item_r) == tpda_pkg::ent_prio(rdata_sel)) &&
                      (tpda_pkg::ent_load(item_r) == tpda_pkg::ent_load(rdata_sel)) &&
                      (tpda_pkg::ent_id(item_r) < tpda_pkg::ent_id(rdata_sel)));

  assign out_free         = ~out_valid_r | out_ready;
  assign sts.full         = (fill_sel == CW'(tpda_pkg::QUEUE_DEPTH));
  assign sts.idx_at_fill  = (idx_r == fill_sel);
  assign sts.idx_at_pos   = (idx_r == pos_r);
  assign sts.both_empty   = (fill_w_r == '0) && (fill_e_r == '0);
  assign sts.out_free     = out_free;

  // grant direction: 0 west, 1 east
  always_comb begin
    if (fill_w_r == '0) begin
      grant_dir = 1'b1;
    end else if (fill_e_r == '0) begin
      grant_dir = 1'b0;
    end else if (run_r >= tpda_pkg::RUN_LIMIT) begin
      grant_dir = (last_r == tpda_pkg::LAST_WEST);
    end else if (tpda_pkg::ent_prio(rdata_w) != tpda_pkg::ent_prio(rdata_e)) begin
      grant_dir = tpda_pkg::ent_prio(rdata_e);
    end else begin
      grant_dir = (last_r == tpda_pkg::LAST_WEST);
    end
  end

  assign do_grant = cmd.res_ld && (cmd.res_code == tpda_pkg::ST_GRANTED);
  assign head     = grant_dir ? rdata_e : rdata_w;
  assign last_nxt = grant_dir ? tpda_pkg::LAST_EAST : tpda_pkg::LAST_WEST;

  always_comb begin
    if (last_r != last_nxt) begin
      run_nxt = 2'd1;
    end else if (run_r < tpda_pkg::RUN_MAX) begin
      run_nxt = run_r + 2'd1;
    end else begin
      run_nxt = run_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      item_r <= {in_train_id, in_high_priority, in_load_time[tpda_pkg::LOAD_BITS-1:0]};
      dir_r  <= in_heading;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_fill) begin
      idx_r <= fill_sel;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - CW'(1);
    end
    if (cmd.pos_set) begin
      pos_r <= idx_r;
    end
    if (cmd.res_ld) begin
      out_status_r <= cmd.res_code;
      out_id_r     <= do_grant ? tpda_pkg::ent_id(head) : '0;
      out_head_r   <= do_grant ? grant_dir : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_w_r    <= '0;
      fill_e_r    <= '0;
      base_w_r    <= '0;
      base_e_r    <= '0;
      last_r      <= tpda_pkg::LAST_NONE;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.res_ld && cmd.res_code == tpda_pkg::ST_ENQUEUED) begin
        if (dir_r) begin
          fill_e_r <= fill_e_r + CW'(1);
        end else begin
          fill_w_r <= fill_w_r + CW'(1);
        end
      end
      if (do_grant) begin
        last_r <= last_nxt;
        run_r  <= run_nxt;
        if (grant_dir) begin
          fill_e_r <= fill_e_r - CW'(1);
          base_e_r <= (base_e_r == IW'(tpda_pkg::QUEUE_DEPTH - 1)) ? '0 : base_e_r + IW'(1);
        end else begin
          fill_w_r <= fill_w_r - CW'(1);
          base_w_r <= (base_w_r == IW'(tpda_pkg::QUEUE_DEPTH - 1)) ? '0 : base_w_r + IW'(1);
        end
      end
      if (cmd.res_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_id      = out_id_r;
  assign out_granted_heading = out_head_r;

endmodule

/* hdl/two_way_priority_dispatch_arbiter.sv */
// Two-way priority dispatch arbiter: ordered west/east request queues.
// Dispatch reads the heads (S_DRD), then loads the grant (S_DSEL), or the empty result in
// S_DRD when both queues are empty. Enqueue scans entries (S_SCAN/S_SCMP) for the slot,
// shifts later entries up (S_SHIFT/S_SHWR per slot, one-read-port queue RAM) and writes
// the item; a full-queue drop's result loads in S_ENQ. One request in flight, the next is
// accepted the cycle after the result loads. Sync active-low reset clears queues and FSM.
module two_way_priority_dispatch_arbiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [tpda_pkg::ID_W-1:0]         in_train_id,
  input  logic                              in_heading,
  input  logic                              in_high_priority,
  input  logic [15:0]                       in_load_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [tpda_pkg::ID_W-1:0]         out_granted_id,
  output logic                              out_granted_heading
);

  tpda_pkg::dp_cmd_t cmd;
  tpda_pkg::dp_sts_t sts;

  tpda_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .in_ready(in_ready), .sts(sts), .cmd(cmd)
  );

  tpda_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_train_id(in_train_id), .in_heading(in_heading),
    .in_high_priority(in_high_priority), .in_load_time(in_load_time),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_granted_id(out_granted_id), .out_granted_heading(out_granted_heading)
  );

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a request while busy");

  // results only come out of a busy controller
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> !in_ready)
    else $error("result loaded while idle");

  // non-grant results carry zero id and heading
  a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != tpda_pkg::ST_GRANTED) |->
      (out_granted_id == '0 && !out_granted_heading))
    else $error("non-grant result with id set");

  // shift and item writes never overlap
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_item && cmd.wr_shift))
    else $error("conflicting queue writes");

endmodule
